// File: design/assert_macros.svh
// Shared assertion shorthands for the decoder blocks.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Condition must never be true while out of reset.
`define ASSERT_NEVER(label, cond, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) !(cond)) \
        else $error(msg);

// Antecedent in one cycle implies consequent in the next.
`define ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// File: design/tfd_pkg.sv
package tfd_pkg;

    // Frame delimiters
    localparam logic [7:0] STX_BYTE = 8'h02;
    localparam logic [7:0] ETX_BYTE = 8'h03;

    // Reserved element overhead added before its limit check
    localparam logic [32:0] RSV_OVERHEAD = 33'd4;

    // Configuration register indexes
    localparam logic [1:0] CFG_FRAME_KIND     = 2'd0;
    localparam logic [1:0] CFG_URL_LIMIT      = 2'd1;
    localparam logic [1:0] CFG_PARAM_LIMIT    = 2'd2;
    localparam logic [1:0] CFG_RESERVED_LIMIT = 2'd3;

    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 13;

    // Configuration reset values
    localparam logic              RST_FRAME_KIND     = 1'b1;
    localparam logic [CFG_DATA_W-1:0] RST_URL_LIMIT      = 13'd1024;
    localparam logic [CFG_DATA_W-1:0] RST_PARAM_LIMIT    = 13'd256;
    localparam logic [CFG_DATA_W-1:0] RST_RESERVED_LIMIT = 13'd1024;

    // Result kinds
    localparam logic [1:0] KIND_SCALAR   = 2'd0;
    localparam logic [1:0] KIND_STR_START = 2'd1;
    localparam logic [1:0] KIND_STR_BYTE = 2'd2;
    localparam logic [1:0] KIND_STATUS   = 2'd3;

    // Frame status codes
    localparam logic [2:0] ST_OK        = 3'd0;
    localparam logic [2:0] ST_SHORT     = 3'd1;
    localparam logic [2:0] ST_BAD_DELIM = 3'd2;
    localparam logic [2:0] ST_EMPTY     = 3'd3;
    localparam logic [2:0] ST_STR_LONG  = 3'd4;
    localparam logic [2:0] ST_BUF_LONG  = 3'd5;
    localparam logic [2:0] ST_TRUNC     = 3'd6;

    // Tags of the request set
    localparam logic [7:0] TAG_REQ_SEQ   = 8'd1;
    localparam logic [7:0] TAG_REQ_URL   = 8'd2;
    localparam logic [7:0] TAG_REQ_RSV   = 8'd3;
    // Tags of the response set
    localparam logic [7:0] TAG_RSP_CODE  = 8'd4;
    localparam logic [7:0] TAG_RSP_SEQ   = 8'd5;
    localparam logic [7:0] TAG_RSP_LEVEL = 8'd8;
    localparam logic [7:0] TAG_RSP_PARAM = 8'd9;
    localparam logic [7:0] TAG_RSP_RSV   = 8'd10;

    // Result queue geometry (depth is a power of two)
    localparam int QDEPTH = 4;
    localparam int QAW    = $clog2(QDEPTH);
    localparam int QCW    = $clog2(QDEPTH + 1);

    typedef enum logic [2:0] {
        CLS_UNKNOWN,
        CLS_SCALAR,
        CLS_CODE,
        CLS_STRING,
        CLS_RESERVED
    } t_cls;

    typedef struct packed {
        logic [7:0] data_byte;
        logic       frame_end;
    } t_in_item;

    typedef struct packed {
        logic [1:0]  kind;
        logic [7:0]  tag;
        logic [31:0] value;
        logic [2:0]  status;
    } t_out_item;

    // Map a tag to its element class under the selected tag set
    function automatic t_cls classify(input logic kind_rsp, input logic [7:0] tag);
        t_cls cls;
        cls = CLS_UNKNOWN;
        if (!kind_rsp) begin
            if (tag == TAG_REQ_SEQ) cls = CLS_SCALAR;
            else if (tag == TAG_REQ_URL) cls = CLS_STRING;
            else if (tag == TAG_REQ_RSV) cls = CLS_RESERVED;
        end else begin
            if (tag == TAG_RSP_CODE) cls = CLS_CODE;
            else if (tag >= TAG_RSP_SEQ && tag <= TAG_RSP_LEVEL) cls = CLS_SCALAR;
            else if (tag == TAG_RSP_PARAM) cls = CLS_STRING;
            else if (tag == TAG_RSP_RSV) cls = CLS_RESERVED;
        end
        return cls;
    endfunction

endpackage

// File: design/tlv_frame_decoder.sv
// Streaming TLV frame decoder. Takes one frame byte per cycle (frame_end set on the
// final byte) and gives at most one result per byte: scalar values, string start
// with length, string bytes, and one frame status per frame. The parser accepts a
// byte every cycle while its four-entry result queue has room; a result passes through
// the queue and then the output register before it reaches the output, and up to five
// results (four in the queue, one in the output register) can wait on a stalled output
// before the input is held. Configuration writes take effect at once and are meant to be
// made between frames.
module tlv_frame_decoder
    import tfd_pkg::*;
(
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_in_valid,
    output logic                  o_in_ready,
    input  t_in_item              i_in_data,
    output logic                  o_out_valid,
    input  logic                  i_out_ready,
    output t_out_item             o_out_data,
    input  logic                  i_cfg_we,
    input  logic [CFG_IDX_W-1:0]  i_cfg_idx,
    input  logic [CFG_DATA_W-1:0] i_cfg_data
);

    logic      q_full;
    logic      push;
    t_out_item push_item;
    logic      pop;
    logic      q_valid;
    t_out_item q_item;

    tfd_front u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_valid     (i_in_valid),
        .o_ready     (o_in_ready),
        .i_item      (i_in_data),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_idx   (i_cfg_idx),
        .i_cfg_data  (i_cfg_data),
        .i_q_full    (q_full),
        .o_push      (push),
        .o_push_item (push_item)
    );

    tfd_queue u_queue (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_push      (push),
        .i_push_item (push_item),
        .o_full      (q_full),
        .i_pop       (pop),
        .o_valid     (q_valid),
        .o_item      (q_item)
    );

    tfd_back u_back (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_q_valid (q_valid),
        .i_q_item  (q_item),
        .o_pop     (pop),
        .o_valid   (o_out_valid),
        .i_ready   (i_out_ready),
        .o_item    (o_out_data)
    );

endmodule

// File: design/tfd_front.sv
`include "assert_macros.svh"

module tfd_front
    import tfd_pkg::*;
(
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_valid,
    output logic                  o_ready,
    input  t_in_item              i_item,
    input  logic                  i_cfg_we,
    input  logic [CFG_IDX_W-1:0]  i_cfg_idx,
    input  logic [CFG_DATA_W-1:0] i_cfg_data,
    input  logic                  i_q_full,
    output logic                  o_push,
    output t_out_item             o_push_item
);

    typedef enum logic [2:0] {
        PH_IDLE,
        PH_TAG,
        PH_LEN,
        PH_VALUE,
        PH_SKIP
    } t_phase;

    t_phase                r_phase, n_phase;
    logic [1:0]            r_hdr, n_hdr;
    logic [7:0]            r_tag, n_tag;
    logic [31:0]           r_rem, n_rem;
    logic [31:0]           r_acc, n_acc;
    logic [2:0]            r_vcnt, n_vcnt;
    logic [2:0]            r_err, n_err;
    logic [1:0]            r_fbc, n_fbc;
    logic                  r_start_ok, n_start_ok;

    logic                  r_frame_kind;
    logic [CFG_DATA_W-1:0] r_url_limit;
    logic [CFG_DATA_W-1:0] r_param_limit;
    logic [CFG_DATA_W-1:0] r_rsv_limit;

    logic                  accept;
    logic [1:0]            cnt;
    t_cls                  cls;
    logic [31:0]           len_new;
    logic [31:0]           rem_dec;
    logic [CFG_DATA_W-1:0] str_limit;
    logic                  str_bad;
    logic                  rsv_bad;
    logic [2:0]            vwidth;
    logic [2:0]            frame_st;

    assign o_ready = !i_q_full;
    assign accept  = i_valid && o_ready;

    // Saturating byte count of the frame so far, this byte included
    assign cnt = (r_fbc == 2'd3) ? 2'd3 : r_fbc + 2'd1;

    assign cls       = classify(r_frame_kind, r_tag);
    assign len_new   = {r_rem[23:0], i_item.data_byte};
    assign rem_dec   = r_rem - 32'd1;
    assign str_limit = r_frame_kind ? r_param_limit : r_url_limit;
    assign str_bad   = len_new >= {19'd0, str_limit};
    assign rsv_bad   = ({1'b0, len_new} + RSV_OVERHEAD) > {20'd0, r_rsv_limit};
    assign vwidth    = (cls == CLS_CODE) ? 3'd1 : 3'd4;

    // Frame status in priority order
    always_comb begin
        priority if (cnt < 2'd2) begin
            frame_st = ST_SHORT;
        end else if (!r_start_ok || i_item.data_byte != ETX_BYTE) begin
            frame_st = ST_BAD_DELIM;
        end else if (cnt == 2'd2) begin
            frame_st = ST_EMPTY;
        end else if (r_err != ST_OK) begin
            frame_st = r_err;
        end else if (r_phase == PH_LEN || r_phase == PH_VALUE) begin
            frame_st = ST_TRUNC;
        end else begin
            frame_st = ST_OK;
        end
    end

    // Per-byte parse step
    always_comb begin
        n_phase     = r_phase;
        n_hdr       = r_hdr;
        n_tag       = r_tag;
        n_rem       = r_rem;
        n_acc       = r_acc;
        n_vcnt      = r_vcnt;
        n_err       = r_err;
        n_fbc       = r_fbc;
        n_start_ok  = r_start_ok;
        o_push      = 1'b0;
        o_push_item = '0;

        if (accept) begin
            if (i_item.frame_end) begin
                // Report the frame and clear for the next one
                o_push             = 1'b1;
                o_push_item.kind   = KIND_STATUS;
                o_push_item.status = frame_st;
                n_phase    = PH_IDLE;
                n_hdr      = '0;
                n_tag      = '0;
                n_rem      = '0;
                n_acc      = '0;
                n_vcnt     = '0;
                n_err      = ST_OK;
                n_fbc      = '0;
                n_start_ok = 1'b0;
            end else begin
                n_fbc = cnt;
                unique case (r_phase)
                    PH_IDLE: begin
                        n_start_ok = (i_item.data_byte == STX_BYTE);
                        n_phase    = (i_item.data_byte == STX_BYTE) ? PH_TAG : PH_SKIP;
                    end
                    PH_TAG: begin
                        n_tag   = i_item.data_byte;
                        n_hdr   = '0;
                        n_rem   = '0;
                        n_phase = PH_LEN;
                    end
                    PH_LEN: begin
                        n_rem = len_new;
                        n_hdr = r_hdr + 2'd1;
                        if (r_hdr == 2'd3) begin
                            n_acc  = '0;
                            n_vcnt = '0;
                            unique case (cls)
                                CLS_SCALAR, CLS_CODE: begin
                                    if (len_new == 32'd0) begin
                                        o_push           = 1'b1;
                                        o_push_item.kind = KIND_SCALAR;
                                        o_push_item.tag  = r_tag;
                                        n_phase          = PH_TAG;
                                    end else begin
                                        n_phase = PH_VALUE;
                                    end
                                end
                                CLS_STRING, CLS_RESERVED: begin
                                    if ((cls == CLS_STRING) ? str_bad : rsv_bad) begin
                                        n_err   = (cls == CLS_STRING) ? ST_STR_LONG
                                                                      : ST_BUF_LONG;
                                        n_phase = PH_SKIP;
                                    end else begin
                                        o_push            = 1'b1;
                                        o_push_item.kind  = KIND_STR_START;
                                        o_push_item.tag   = r_tag;
                                        o_push_item.value = len_new;
                                        n_phase = (len_new != 32'd0) ? PH_VALUE : PH_TAG;
                                    end
                                end
                                default: begin
                                    n_phase = (len_new != 32'd0) ? PH_VALUE : PH_TAG;
                                end
                            endcase
                        end
                    end
                    PH_VALUE: begin
                        n_rem = rem_dec;
                        unique case (cls)
                            CLS_SCALAR, CLS_CODE: begin
                                if (r_vcnt < vwidth) begin
                                    n_acc  = {r_acc[23:0], i_item.data_byte};
                                    n_vcnt = r_vcnt + 3'd1;
                                end
                                if (rem_dec == 32'd0) begin
                                    o_push            = 1'b1;
                                    o_push_item.kind  = KIND_SCALAR;
                                    o_push_item.tag   = r_tag;
                                    o_push_item.value = n_acc;
                                end
                            end
                            CLS_STRING, CLS_RESERVED: begin
                                o_push            = 1'b1;
                                o_push_item.kind  = KIND_STR_BYTE;
                                o_push_item.tag   = r_tag;
                                o_push_item.value = {24'd0, i_item.data_byte};
                            end
                            default: begin
                            end
                        endcase
                        if (rem_dec == 32'd0) begin
                            n_phase = PH_TAG;
                        end
                    end
                    PH_SKIP: begin
                    end
                    default: begin
                        n_phase = PH_IDLE;
                    end
                endcase
            end
        end
    end

    // Hold parse state and configuration
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase       <= PH_IDLE;
            r_hdr         <= '0;
            r_tag         <= '0;
            r_rem         <= '0;
            r_acc         <= '0;
            r_vcnt        <= '0;
            r_err         <= ST_OK;
            r_fbc         <= '0;
            r_start_ok    <= 1'b0;
            r_frame_kind  <= RST_FRAME_KIND;
            r_url_limit   <= RST_URL_LIMIT;
            r_param_limit <= RST_PARAM_LIMIT;
            r_rsv_limit   <= RST_RESERVED_LIMIT;
        end else begin
            r_phase    <= n_phase;
            r_hdr      <= n_hdr;
            r_tag      <= n_tag;
            r_rem      <= n_rem;
            r_acc      <= n_acc;
            r_vcnt     <= n_vcnt;
            r_err      <= n_err;
            r_fbc      <= n_fbc;
            r_start_ok <= n_start_ok;
            if (i_cfg_we) begin
                unique case (i_cfg_idx)
                    CFG_FRAME_KIND:     r_frame_kind  <= i_cfg_data[0];
                    CFG_URL_LIMIT:      r_url_limit   <= i_cfg_data;
                    CFG_PARAM_LIMIT:    r_param_limit <= i_cfg_data;
                    CFG_RESERVED_LIMIT: r_rsv_limit   <= i_cfg_data;
                    default: begin
                    end
                endcase
            end
        end
    end

    `ASSERT_NEXT(a_frame_clears, accept && i_item.frame_end, r_phase == PH_IDLE && r_fbc == 2'd0 && r_err == ST_OK, "frame state not cleared after final byte")
    `ASSERT_NEVER(a_status_only_at_end, o_push && o_push_item.kind == KIND_STATUS && !(accept && i_item.frame_end), "status result without final byte")
    `ASSERT_NEVER(a_no_push_when_full, o_push && i_q_full, "result pushed while queue full")

endmodule

// File: design/tfd_queue.sv
`include "assert_macros.svh"

module tfd_queue
    import tfd_pkg::*;
(
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_push,
    input  t_out_item i_push_item,
    output logic      o_full,
    input  logic      i_pop,
    output logic      o_valid,
    output t_out_item o_item
);

    t_out_item          r_mem [QDEPTH];
    logic [QAW-1:0]     r_wr_ptr;
    logic [QAW-1:0]     r_rd_ptr;
    logic [QCW-1:0]     r_count;

    assign o_full  = (r_count == QCW'(QDEPTH));
    assign o_valid = (r_count != '0);
    assign o_item  = r_mem[r_rd_ptr];

    // Store pushed results
    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr_ptr] <= i_push_item;
        end
    end

    // Advance pointers and occupancy
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (i_push) begin
                r_wr_ptr <= r_wr_ptr + QAW'(1);
            end
            if (i_pop) begin
                r_rd_ptr <= r_rd_ptr + QAW'(1);
            end
            if (i_push && !i_pop) begin
                r_count <= r_count + QCW'(1);
            end else if (!i_push && i_pop) begin
                r_count <= r_count - QCW'(1);
            end
        end
    end

    `ASSERT_NEVER(a_no_overflow, i_push && o_full, "push into full result queue")
    `ASSERT_NEVER(a_no_underflow, i_pop && !o_valid, "pop from empty result queue")
    `ASSERT_NEXT(a_count_up, i_push && !i_pop, r_count == $past(r_count) + QCW'(1), "queue count did not advance on push")

endmodule

// File: design/tfd_back.sv
module tfd_back
    import tfd_pkg::*;
(
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_q_valid,
    input  t_out_item i_q_item,
    output logic      o_pop,
    output logic      o_valid,
    input  logic      i_ready,
    output t_out_item o_item
);

    logic      r_valid;
    t_out_item r_item;

    // Load the output register from the queue whenever it is empty or being drained and the queue holds a result
    assign o_pop   = i_q_valid && (!r_valid || i_ready);
    assign o_valid = r_valid;
    assign o_item  = r_item;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (!r_valid || i_ready) begin
            r_valid <= i_q_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_pop) begin
            r_item <= i_q_item;
        end
    end

endmodule
